@@ sv/bmbd_pkg.sv @@
// Shared types, address map constants and physical memory layout for the
// banked memory bus decoder. No dependencies.
`default_nettype none
package bmbd_pkg;

    localparam int VideoBankBytes = 8192;
    localparam int WorkBankBytes  = 4096;
    localparam int VideoBanks     = 2;
    localparam int WorkBanks      = 8;

    // Unified backing store: video RAM, work RAM, sprite RAM, IO and high RAM.
    localparam int VramBase = 0;
    localparam int WramBase = 32768;
    localparam int OamBase  = 65536;
    localparam int IoBase   = OamBase + 256;
    localparam int HramBase = IoBase + 128;
    localparam int MemDepth = HramBase + 128;
    localparam int MemAddrW = $clog2(MemDepth);

    localparam int VidIdxW  = $clog2(VideoBanks * VideoBankBytes);
    localparam int WorkIdxW = $clog2(WorkBanks * WorkBankBytes);
    localparam int VidOffW  = $clog2(VideoBankBytes);
    localparam int WorkOffW = $clog2(WorkBankBytes);
    localparam int WorkSelW = $clog2(WorkBanks);
    localparam int IoIdxW   = 7;

    localparam logic [15:0] AddrOamEnd    = 16'hFE9F;
    localparam logic [15:0] AddrUnusedEnd = 16'hFEFF;
    localparam logic [15:0] AddrIf        = 16'hFF0F;
    localparam logic [15:0] AddrVbk       = 16'hFF4F;
    localparam logic [15:0] AddrSvbk      = 16'hFF70;
    localparam logic [15:0] AddrIoEnd     = 16'hFF7F;
    localparam logic [15:0] AddrIe        = 16'hFFFF;
    localparam logic [15:0] AddrWramEnd   = 16'hFDFF;

    localparam logic [7:0] UnusedByte  = 8'hFF;
    localparam logic [7:0] VbkReadMask  = 8'hFE;
    localparam logic [7:0] SvbkReadMask = 8'hF8;

    localparam logic ReqRead  = 1'b0;
    localparam logic ReqWrite = 1'b1;

    typedef enum logic [3:0] {
        RG_CART, RG_VRAM, RG_WRAM, RG_OAM, RG_UNUSED,
        RG_IF, RG_VBK, RG_SVBK, RG_IO, RG_HRAM, RG_IE
    } t_region;

    typedef struct packed {
        logic        req_type;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       to_cartridge;
    } t_out_item;

    // Decode result handed from the decoder to the memory and pipeline.
    typedef struct packed {
        logic                mem_rd;
        logic                mem_wr;
        logic [MemAddrW-1:0] mem_addr;
        logic                use_mem;
        logic [7:0]          local_rdata;
        logic                cart;
    } t_dec;

endpackage
`default_nettype wire

@@ sv/bmbd_mem.sv @@
// Single-port synchronous backing store with a registered read port.
// Depends on bmbd_pkg for the depth and address width.
`default_nettype none
module bmbd_mem
    import bmbd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic                i_re,
    input  wire logic [MemAddrW-1:0] i_addr,
    input  wire logic [7:0]          i_wdata,
    output logic      [7:0]          o_rdata
);

    logic [7:0] r_mem [0:MemDepth-1];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // The read data holds while no new read is issued.
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

@@ sv/bmbd_decode.sv @@
// Address decoder with the bank select, IF and IE registers and the IO
// written flags. Depends on bmbd_pkg.
`default_nettype none
module bmbd_decode
    import bmbd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_req,
    output t_dec          o_dec
);

    logic                r_vbk;
    logic [WorkSelW-1:0] r_svbk;
    logic [7:0]          r_if;
    logic [7:0]          r_ie;
    logic [127:0]        r_io_valid;

    t_region       region;
    logic          wr;
    logic [15:0]   a;
    logic [VidIdxW-1:0]  vid_idx;
    logic [WorkIdxW-1:0] work_idx;
    logic [WorkSelW-1:0] svbk_wr;

    assign wr = (i_req.req_type == ReqWrite);
    assign a  = i_req.addr;

    always_comb begin
        if (!a[15] || a[15:13] == 3'b101) begin
            region = RG_CART;
        end else if (a[15:13] == 3'b100) begin
            region = RG_VRAM;
        end else if (a <= AddrWramEnd) begin
            region = RG_WRAM;
        end else if (a <= AddrOamEnd) begin
            region = RG_OAM;
        end else if (a <= AddrUnusedEnd) begin
            region = RG_UNUSED;
        end else if (a == AddrIf) begin
            region = RG_IF;
        end else if (a == AddrVbk) begin
            region = RG_VBK;
        end else if (a == AddrSvbk) begin
            region = RG_SVBK;
        end else if (a <= AddrIoEnd) begin
            region = RG_IO;
        end else if (a != AddrIe) begin
            region = RG_HRAM;
        end else begin
            region = RG_IE;
        end
    end

    // The echo region differs from work RAM only in bit 13, so the low
    // twelve bits and bit 12 serve both.
    assign vid_idx  = {r_vbk, a[VidOffW-1:0]};
    assign work_idx = a[WorkOffW] ? {r_svbk, a[WorkOffW-1:0]}
                                  : {{WorkSelW{1'b0}}, a[WorkOffW-1:0]};
    assign svbk_wr  = (i_req.wdata[WorkSelW-1:0] == '0) ? WorkSelW'(1)
                                                        : i_req.wdata[WorkSelW-1:0];

    always_comb begin
        o_dec = '0;
        unique case (region)
            RG_CART: begin
                o_dec.cart = 1'b1;
            end
            RG_VRAM: begin
                o_dec.mem_addr = MemAddrW'(VramBase) + MemAddrW'(vid_idx);
                o_dec.use_mem  = 1'b1;
            end
            RG_WRAM: begin
                o_dec.mem_addr = MemAddrW'(WramBase) + MemAddrW'(work_idx);
                o_dec.use_mem  = 1'b1;
            end
            RG_OAM: begin
                o_dec.mem_addr = MemAddrW'(OamBase) + MemAddrW'(a[7:0]);
                o_dec.use_mem  = 1'b1;
            end
            RG_UNUSED: begin
                o_dec.local_rdata = UnusedByte;
            end
            RG_IF: begin
                o_dec.local_rdata = r_if;
            end
            RG_VBK: begin
                o_dec.local_rdata = VbkReadMask | {7'd0, r_vbk};
            end
            RG_SVBK: begin
                o_dec.local_rdata = SvbkReadMask | {{(8-WorkSelW){1'b0}}, r_svbk};
            end
            RG_IO: begin
                o_dec.mem_addr = MemAddrW'(IoBase) + MemAddrW'(a[IoIdxW-1:0]);
                // A cell never written is not read from the store; it returns the local value of zero.
                o_dec.use_mem  = r_io_valid[a[IoIdxW-1:0]];
            end
            RG_HRAM: begin
                o_dec.mem_addr = MemAddrW'(HramBase) + MemAddrW'(a[IoIdxW-1:0]);
                o_dec.use_mem  = 1'b1;
            end
            RG_IE: begin
                o_dec.local_rdata = r_ie;
            end
            default: begin
                o_dec.cart = 1'b0;
            end
        endcase
        o_dec.mem_wr = i_accept && wr && (region == RG_VRAM || region == RG_WRAM
                       || region == RG_OAM || region == RG_IO || region == RG_HRAM);
        o_dec.mem_rd = i_accept && !wr && o_dec.use_mem;
        if (wr || o_dec.cart) begin
            o_dec.use_mem     = 1'b0;
            o_dec.local_rdata = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbk      <= 1'b0;
            r_svbk     <= WorkSelW'(1);
            r_if       <= 8'd0;
            r_ie       <= 8'd0;
            r_io_valid <= '0;
        end else if (i_accept && wr) begin
            case (region)
                RG_IF:   r_if   <= i_req.wdata;
                RG_IE:   r_ie   <= i_req.wdata;
                RG_VBK:  r_vbk  <= i_req.wdata[0];
                RG_SVBK: r_svbk <= svbk_wr;
                RG_IO:   r_io_valid[a[IoIdxW-1:0]] <= 1'b1;
                default: r_if   <= r_if;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/banked_memory_bus_decoder.sv @@
// Banked memory bus decoder top level: decoder, backing store and the
// read and output stages. Depends on bmbd_pkg, bmbd_decode and bmbd_mem.
//
// Usage: the CPU side presents one byte transfer on i_in_valid/i_in_data
// (req_type, addr, wdata); it is taken at an edge where o_in_stall is low.
// Each transfer yields one result on o_out_valid/o_out_data (rdata,
// to_cartridge), taken at an edge where i_out_stall is low.
// A transfer passes from acceptance through the synchronous read of the
// backing store into the output register before o_out_valid rises.
// Throughput is one transfer per cycle while i_out_stall is low; the single
// store port serves the one read or write of each transfer, and bank
// registers written by a transfer take effect for the very next one.
// When the receiver stalls, the output register holds and one more
// transfer is taken into the read stage; after that o_in_stall rises
// until the output drains.
// Synchronous reset clears the pipeline, IF, IE, VBK, sets SVBK to bank
// one and marks all IO cells as zero. There is no clearing pass.
`default_nettype none
module banked_memory_bus_decoder
    import bmbd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    t_dec       dec;
    logic       accept;
    logic       advance;
    logic [7:0] mem_q;

    logic       r_s1_valid;
    logic       r_s1_use_mem;
    logic [7:0] r_s1_local;
    logic       r_s1_cart;
    logic       r_out_valid;
    t_out_item  r_out;

    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    bmbd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_data),
        .o_dec    (dec)
    );

    bmbd_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (dec.mem_wr),
        .i_re    (dec.mem_rd),
        .i_addr  (dec.mem_addr),
        .i_wdata (i_in_data.wdata),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_use_mem <= dec.use_mem;
            r_s1_local   <= dec.local_rdata;
            r_s1_cart    <= dec.cart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out.rdata        <= r_s1_use_mem ? mem_q : r_s1_local;
            r_out.to_cartridge <= r_s1_cart;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ bench/banked_memory_bus_decoder_tb.sv @@
// Self-checking testbench for banked_memory_bus_decoder: directed and random byte
// transfers across the whole memory map, checked against a behavioral memory map.
// Depends on bmbd_pkg and the banked_memory_bus_decoder RTL.
module banked_memory_bus_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmbd_pkg::*;

    localparam int CycleLimit = 100000;
    localparam int PhaseItems = 182;
    // Keys into the written-cell map, one range per store.
    localparam int KeyWram  = 16384;
    localparam int KeyOam   = 49152;
    localparam int KeyHram  = 49408;
    localparam int KeyCount = 49536;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    banked_memory_bus_decoder DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_item)
    );

    // Stimulus side: transfers waiting to be driven and the generator's view of the map.
    t_in_item    pending_transfers[$];
    logic [15:0] recent_writes[$];
    bit          filled[KeyCount];
    logic        plan_vid_sel = 1'b0;
    logic [2:0]  plan_work_sel = 3'd1;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    // Predicted memory map state.
    logic [7:0] vid_mem[VideoBanks * VideoBankBytes];
    logic [7:0] work_mem[WorkBanks * WorkBankBytes];
    logic [7:0] oam_mem[160];
    logic [7:0] io_mem[128];
    logic [7:0] hi_mem[127];
    logic [7:0] if_reg = 8'h00;
    logic [7:0] ie_reg = 8'h00;
    logic       vid_sel = 1'b0;
    logic [2:0] work_sel = 3'd1;

    t_out_item expected_results[$];
    int        fail_count = 0;
    int        cycles = 0;
    int        n_reads = 0;
    int        n_writes = 0;
    int        n_forwarded = 0;
    int        n_checked = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        foreach (io_mem[i]) io_mem[i] = 8'h00;
    end

    // Region of an address and the cell index inside that region's store.
    function automatic t_region locate(input logic [15:0] a, input logic vs,
                                       input logic [2:0] ws, output int idx);
        int m;
        idx = 0;
        m = int'(a);
        if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) return RG_CART;
        if (a <= 16'h9FFF) begin
            idx = int'(vs) * VideoBankBytes + (m - 'h8000);
            return RG_VRAM;
        end
        if (a <= AddrWramEnd) begin
            if (m >= 'hE000) m = m - 'h2000;
            if (m < 'hD000) idx = m - 'hC000;
            else idx = int'(ws) * WorkBankBytes + (m - 'hD000);
            return RG_WRAM;
        end
        if (a <= AddrOamEnd) begin
            idx = m - 'hFE00;
            return RG_OAM;
        end
        if (a <= AddrUnusedEnd) return RG_UNUSED;
        if (a == AddrIf) return RG_IF;
        if (a == AddrVbk) return RG_VBK;
        if (a == AddrSvbk) return RG_SVBK;
        if (a <= AddrIoEnd) begin
            idx = m - 'hFF00;
            return RG_IO;
        end
        if (a < AddrIe) begin
            idx = m - 'hFF80;
            return RG_HRAM;
        end
        return RG_IE;
    endfunction

    // Queues a transfer. A read of a video, work, sprite or high RAM cell not yet written becomes a write.
    task automatic plan(input logic rq, input logic [15:0] a, input logic [7:0] d);
        t_in_item it;
        t_region  rg;
        int       idx;
        int       key;
        rg = locate(a, plan_vid_sel, plan_work_sel, idx);
        case (rg)
            RG_VRAM: key = idx;
            RG_WRAM: key = KeyWram + idx;
            RG_OAM:  key = KeyOam + idx;
            RG_HRAM: key = KeyHram + idx;
            default: key = -1;
        endcase
        if (rq == ReqRead && key >= 0 && !filled[key]) rq = ReqWrite;
        if (rq == ReqWrite) begin
            if (key >= 0) begin
                filled[key] = 1'b1;
                recent_writes.push_back(a);
                if (recent_writes.size() > 64) void'(recent_writes.pop_front());
            end
            if (rg == RG_VBK) plan_vid_sel = d[0];
            if (rg == RG_SVBK) plan_work_sel = (d[2:0] == 3'd0) ? 3'd1 : d[2:0];
        end
        it.req_type = rq;
        it.addr = a;
        it.wdata = d;
        pending_transfers.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_transfers.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Applies one transfer to the predicted map and returns the expected result.
    function automatic t_out_item access_memory_map(input t_in_item it);
        t_out_item res;
        t_region   rg;
        int        idx;
        logic      wr;
        wr = (it.req_type == ReqWrite);
        rg = locate(it.addr, vid_sel, work_sel, idx);
        res.rdata = 8'h00;
        res.to_cartridge = (rg == RG_CART);
        case (rg)
            RG_VRAM: if (wr) vid_mem[idx] = it.wdata; else res.rdata = vid_mem[idx];
            RG_WRAM: if (wr) work_mem[idx] = it.wdata; else res.rdata = work_mem[idx];
            RG_OAM:  if (wr) oam_mem[idx] = it.wdata; else res.rdata = oam_mem[idx];
            RG_IO:   if (wr) io_mem[idx] = it.wdata; else res.rdata = io_mem[idx];
            RG_HRAM: if (wr) hi_mem[idx] = it.wdata; else res.rdata = hi_mem[idx];
            RG_IF:   if (wr) if_reg = it.wdata; else res.rdata = if_reg;
            RG_IE:   if (wr) ie_reg = it.wdata; else res.rdata = ie_reg;
            RG_UNUSED: if (!wr) res.rdata = UnusedByte;
            RG_VBK: begin
                if (wr) vid_sel = it.wdata[0];
                else res.rdata = VbkReadMask | {7'b0, vid_sel};
            end
            RG_SVBK: begin
                // Bank zero cannot be selected in the switchable window; it maps to one.
                if (wr) work_sel = (it.wdata[2:0] == 3'd0) ? 3'd1 : it.wdata[2:0];
                else res.rdata = SvbkReadMask | {5'b0, work_sel};
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_transfers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item <= pending_transfers.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(access_memory_map(in_item));
                if (in_item.req_type == ReqWrite) n_writes++;
                else n_reads++;
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected: rdata %h to_cartridge %b",
                             $time, out_item.rdata, out_item.to_cartridge);
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.to_cartridge) n_forwarded++;
                    if (out_item.rdata !== want.rdata) begin
                        fail_count++;
                        $display("%0t: rdata mismatch: expected %h actual %h",
                                 $time, want.rdata, out_item.rdata);
                    end
                    if (out_item.to_cartridge !== want.to_cartridge) begin
                        fail_count++;
                        $display("%0t: to_cartridge mismatch: expected %b actual %b",
                                 $time, want.to_cartridge, out_item.to_cartridge);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("banked_memory_bus_decoder verification failed");
            $finish;
        end
    end

    initial begin
        int          kind;
        logic        rq;
        logic [15:0] a;
        logic [15:0] base;
        int          span;
        int          off;
        logic [7:0]  d;
        int          idle_set[4];
        int          stall_set[4];

        idle_set = '{0, 51, 0, 12};
        stall_set = '{0, 0, 51, 12};

        // Map boundaries, bank switching, echo aliasing and fixed registers.
        plan(ReqRead, 16'h0000, 8'h00);
        plan(ReqWrite, 16'h7FFF, 8'hFF);
        plan(ReqRead, 16'hA000, 8'h5A);
        plan(ReqWrite, 16'hBFFF, 8'hA5);
        plan(ReqWrite, 16'h8000, 8'h11);
        plan(ReqWrite, AddrVbk, 8'hFF);
        plan(ReqRead, AddrVbk, 8'h00);
        plan(ReqWrite, 16'h8000, 8'h22);
        plan(ReqRead, 16'h8000, 8'h00);
        plan(ReqWrite, AddrVbk, 8'hFE);
        plan(ReqRead, 16'h8000, 8'h00);
        plan(ReqWrite, 16'hC000, 8'h00);
        plan(ReqRead, 16'hE000, 8'h00);
        plan(ReqWrite, AddrSvbk, 8'h00);
        plan(ReqRead, AddrSvbk, 8'h00);
        plan(ReqWrite, AddrSvbk, 8'hFF);
        plan(ReqWrite, 16'hFDFF, 8'hC3);
        plan(ReqRead, 16'hDDFF, 8'h00);
        plan(ReqWrite, AddrOamEnd, 8'h3C);
        plan(ReqRead, AddrOamEnd, 8'h00);
        plan(ReqWrite, 16'hFEA0, 8'h77);
        plan(ReqRead, AddrUnusedEnd, 8'h00);
        plan(ReqRead, 16'hFF00, 8'h00);
        plan(ReqWrite, AddrIf, 8'hE1);
        plan(ReqRead, AddrIf, 8'h00);
        plan(ReqWrite, AddrIe, 8'h1F);
        plan(ReqRead, AddrIe, 8'h00);
        plan(ReqWrite, 16'hFFFE, 8'h80);
        plan(ReqRead, 16'hFFFE, 8'h00);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            // Let every outstanding transfer complete before the next phase starts.
            wait_idle();
            send_idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            for (int n = 0; n < PhaseItems; n++) begin
                kind = $urandom_range(99);
                rq = 1'($urandom_range(1));
                d = 8'($urandom_range(255));
                if (kind < 35 && recent_writes.size() > 0) begin
                    a = recent_writes[$urandom_range(recent_writes.size() - 1)];
                    rq = ReqRead;
                end else if (kind < 60) begin
                    case ($urandom_range(4))
                        0: begin base = 16'h8000; span = 'h2000; end
                        1: begin base = 16'hC000; span = 'h2000; end
                        2: begin base = 16'hE000; span = 'h1E00; end
                        3: begin base = 16'hFE00; span = 'hA0; end
                        default: begin base = 16'hFF80; span = 'h7F; end
                    endcase
                    case ($urandom_range(2))
                        0: off = $urandom_range(15);
                        1: off = span - 1 - $urandom_range(15);
                        default: off = $urandom_range(span - 1);
                    endcase
                    a = base + off[15:0];
                    rq = ReqWrite;
                end else if (kind < 72) begin
                    case ($urandom_range(3))
                        0: a = AddrVbk;
                        1: a = AddrSvbk;
                        2: a = AddrIf;
                        default: a = AddrIe;
                    endcase
                end else if (kind < 82) begin
                    a = 16'hFE00 + 16'($urandom_range('h1FF));
                end else if (kind < 91) begin
                    if ($urandom_range(1)) a = 16'($urandom_range('h7FFF));
                    else a = 16'hA000 + 16'($urandom_range('h1FFF));
                end else begin
                    a = 16'($urandom_range('hFFFF));
                end
                plan(rq, a, d);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Ran %0d transfers (%0d reads, %0d writes), %0d results checked, %0d forwarded.",
                 n_reads + n_writes, n_reads, n_writes, n_checked, n_forwarded);
        $display("Phases: no gaps, sender gaps, receiver stalls, both; %0d mismatches.",
                 fail_count);
        if (fail_count == 0) begin
            $display("banked_memory_bus_decoder verification clean");
        end else begin
            $display("banked_memory_bus_decoder verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bmbd_pkg.sv
sv/bmbd_mem.sv
sv/bmbd_decode.sv
sv/banked_memory_bus_decoder.sv
bench/banked_memory_bus_decoder_tb.sv
